@@ hw/rtl/cdd_pkg.sv @@
// Shared types, codes and constants of the cartridge disk DMA controller.
package cdd_pkg;

  localparam int SECTORS_PER_TRACK = 12;
  localparam int CYLINDERS         = 203;
  localparam int BLOCK_SHIFT       = 9;

  localparam logic [13:0] IMAGE_BLOCKS_RESET = 14'd4872;

  localparam logic [15:0] CS_GO   = 16'h0001;
  localparam logic [15:0] CS_IE   = 16'h0040;
  localparam logic [15:0] CS_DONE = 16'h0080;
  localparam logic [15:0] CS_HERR = 16'h4000;
  localparam logic [15:0] CS_ERR  = 16'h8000;
  localparam logic [15:0] ER_NXS  = 16'h0040;
  localparam logic [15:0] ER_NXC  = 16'h0080;
  localparam logic [15:0] ER_NXM  = 16'h0800;

  typedef enum logic [1:0] {
    REQ_READ     = 2'd0,
    REQ_WRITE    = 2'd1,
    REQ_COMPLETE = 2'd2
  } req_type_e;

  typedef enum logic [2:0] {
    REG_DRIVE_STATUS = 3'd0,
    REG_ERROR        = 3'd1,
    REG_CTRL_STATUS  = 3'd2,
    REG_WORD_COUNT   = 3'd3,
    REG_BUS_ADDR     = 3'd4,
    REG_DISK_ADDR    = 3'd5,
    REG_MAINT        = 3'd6,
    REG_DATA_BUF     = 3'd7
  } reg_index_e;

  typedef enum logic [2:0] {
    FN_CTRL_RESET  = 3'd0,
    FN_WRITE       = 3'd1,
    FN_READ        = 3'd2,
    FN_SEEK        = 3'd3,
    FN_READ_CHECK  = 3'd4,
    FN_WRITE_CHECK = 3'd5,
    FN_DRIVE_RESET = 3'd6,
    FN_WRITE_LOCK  = 3'd7
  } func_e;

  typedef logic [1:0]  req_type_t;
  typedef logic [2:0]  reg_index_t;
  typedef logic [15:0] word_t;
  typedef logic [13:0] image_blocks_t;
  typedef logic [21:0] disk_offset_t;
  typedef logic [16:0] byte_count_t;

  typedef struct packed {
    req_type_t  req_type;
    reg_index_t reg_index;
    word_t      write_data;
    logic       dma_ok;
  } cdd_req_t;

  typedef struct packed {
    word_t        read_data;
    logic         irq_level;
    logic         dma_start;
    logic         dma_to_memory;
    word_t        dma_bus_addr;
    disk_offset_t dma_disk_offset;
    byte_count_t  dma_byte_count;
  } cdd_rsp_t;

  typedef struct packed {
    disk_offset_t offset;
    byte_count_t  bytes;
    logic         sect_bad;
    logic         range_bad;
  } cdd_geom_t;

endpackage

@@ hw/rtl/cdd_if.sv @@
// Valid/ready channel interfaces for request and result beats.
interface cdd_req_if;
  logic                 valid;
  logic                 ready;
  cdd_pkg::req_type_t   req_type;
  cdd_pkg::reg_index_t  reg_index;
  cdd_pkg::word_t       write_data;
  logic                 dma_ok;

  modport source (output valid, output req_type, output reg_index, output write_data,
                  output dma_ok, input ready);
  modport sink (input valid, input req_type, input reg_index, input write_data,
                input dma_ok, output ready);
endinterface

interface cdd_rsp_if;
  logic                   valid;
  logic                   ready;
  cdd_pkg::word_t         read_data;
  logic                   irq_level;
  logic                   dma_start;
  logic                   dma_to_memory;
  cdd_pkg::word_t         dma_bus_addr;
  cdd_pkg::disk_offset_t  dma_disk_offset;
  cdd_pkg::byte_count_t   dma_byte_count;

  modport source (output valid, output read_data, output irq_level, output dma_start,
                  output dma_to_memory, output dma_bus_addr, output dma_disk_offset,
                  output dma_byte_count, input ready);
  modport sink (input valid, input read_data, input irq_level, input dma_start,
                input dma_to_memory, input dma_bus_addr, input dma_disk_offset,
                input dma_byte_count, output ready);
endinterface

@@ hw/rtl/cdd_geom.sv @@
// Disk address decode, byte count and image bound check.
module cdd_geom (
  input  cdd_pkg::word_t         disk_addr,
  input  cdd_pkg::word_t         word_count,
  input  cdd_pkg::image_blocks_t image_blocks,
  output cdd_pkg::cdd_geom_t     geom
);
  import cdd_pkg::*;

  logic [3:0]  sect;
  logic [8:0]  track;
  logic [7:0]  cyl;
  logic [12:0] blk;
  word_t       neg_wc;
  logic [22:0] xfer_end;
  logic [22:0] limit;

  assign sect   = disk_addr[3:0];
  assign track  = disk_addr[12:4];
  assign cyl    = disk_addr[12:5];
  assign neg_wc = 16'(~word_count + 16'd1);
  assign blk    = 13'(track * 13'(SECTORS_PER_TRACK)) + 13'(sect);

  assign geom.bytes     = {neg_wc, 1'b0};
  assign geom.offset    = {blk, {BLOCK_SHIFT{1'b0}}};
  assign limit          = {image_blocks, {BLOCK_SHIFT{1'b0}}};
  assign xfer_end       = {1'b0, geom.offset} + 23'(geom.bytes);
  assign geom.sect_bad  = {1'b0, sect} >= 5'(SECTORS_PER_TRACK);
  assign geom.range_bad = ({1'b0, cyl} >= 9'(CYLINDERS)) || (xfer_end > limit);

endmodule

@@ hw/rtl/cdd_regfile.sv @@
// Controller registers, command decode and per-beat result logic.
module cdd_regfile (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  cdd_pkg::image_blocks_t cfg_wdata,
  input  logic                   fire,
  input  cdd_pkg::cdd_req_t      req,
  output cdd_pkg::cdd_rsp_t      rsp
);
  import cdd_pkg::*;

  image_blocks_t image_blocks_r;
  word_t         cs_r, cs_nxt;
  word_t         err_r, err_nxt;
  word_t         wc_r, wc_nxt;
  word_t         ba_r, ba_nxt;
  word_t         da_r, da_nxt;
  logic          pend_r, pend_nxt;
  word_t         pstart_r, pstart_nxt;
  byte_count_t   pbytes_r, pbytes_nxt;
  word_t         cs_wr;
  word_t         err_done;
  func_e         func;
  cdd_geom_t     geom;

  function automatic word_t finish_cs(input word_t cs, input logic err_nz);
    finish_cs = (cs & ~(CS_GO | CS_HERR | CS_ERR)) | CS_DONE |
                (err_nz ? (CS_HERR | CS_ERR) : 16'h0000);
  endfunction

  cdd_geom u_geom (
    .disk_addr    (da_r),
    .word_count   (wc_r),
    .image_blocks (image_blocks_r),
    .geom         (geom)
  );

  assign cs_wr    = req.write_data & ~CS_DONE;
  assign func     = func_e'(cs_wr[3:1]);
  assign err_done = req.dma_ok ? err_r : ER_NXM;

  always_comb begin
    cs_nxt     = cs_r;
    err_nxt    = err_r;
    wc_nxt     = wc_r;
    ba_nxt     = ba_r;
    da_nxt     = da_r;
    pend_nxt   = pend_r;
    pstart_nxt = pstart_r;
    pbytes_nxt = pbytes_r;
    rsp        = '0;
    if (fire) begin
      unique case (req.req_type)
        REQ_READ: begin
          unique case (reg_index_e'(req.reg_index))
            REG_ERROR:       rsp.read_data = err_r;
            REG_CTRL_STATUS: rsp.read_data = cs_r | ((err_r != 16'h0000) ? CS_ERR : 16'h0000);
            REG_WORD_COUNT:  rsp.read_data = wc_r;
            REG_BUS_ADDR:    rsp.read_data = ba_r;
            REG_DISK_ADDR:   rsp.read_data = da_r;
            default:         rsp.read_data = 16'h0000;
          endcase
        end
        REQ_WRITE: begin
          unique case (reg_index_e'(req.reg_index))
            REG_CTRL_STATUS: begin
              cs_nxt = cs_wr;
              if ((req.write_data & CS_GO) != 16'h0000) begin
                err_nxt  = 16'h0000;
                pend_nxt = 1'b0;
                if (func == FN_WRITE || func == FN_READ) begin
                  if (!geom.sect_bad && !geom.range_bad) begin
                    pend_nxt              = 1'b1;
                    pstart_nxt            = ba_r;
                    pbytes_nxt            = geom.bytes;
                    rsp.dma_start         = 1'b1;
                    rsp.dma_to_memory     = (func == FN_READ);
                    rsp.dma_bus_addr      = ba_r;
                    rsp.dma_disk_offset   = geom.offset;
                    rsp.dma_byte_count    = geom.bytes;
                  end else begin
                    err_nxt = geom.sect_bad ? ER_NXS : ER_NXC;
                    ba_nxt  = ba_r + geom.bytes[15:0];
                    wc_nxt  = 16'h0000;
                    cs_nxt  = finish_cs(cs_wr, 1'b1);
                  end
                end else begin
                  if (func == FN_CTRL_RESET) begin
                    da_nxt = 16'h0000;
                    ba_nxt = 16'h0000;
                  end
                  cs_nxt = finish_cs(cs_wr, 1'b0);
                end
              end
            end
            REG_WORD_COUNT: wc_nxt = req.write_data;
            REG_BUS_ADDR:   ba_nxt = req.write_data;
            REG_DISK_ADDR:  da_nxt = req.write_data;
            default: ;
          endcase
        end
        REQ_COMPLETE: begin
          if (pend_r) begin
            err_nxt  = err_done;
            ba_nxt   = pstart_r + pbytes_r[15:0];
            wc_nxt   = 16'h0000;
            pend_nxt = 1'b0;
            cs_nxt   = finish_cs(cs_r, err_done != 16'h0000);
          end
        end
        default: ;
      endcase
    end
    rsp.irq_level = ((cs_nxt & CS_DONE) != 16'h0000) && ((cs_nxt & CS_IE) != 16'h0000);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_blocks_r <= IMAGE_BLOCKS_RESET;
      cs_r           <= CS_DONE;
      err_r          <= 16'h0000;
      wc_r           <= 16'h0000;
      ba_r           <= 16'h0000;
      da_r           <= 16'h0000;
      pend_r         <= 1'b0;
      pstart_r       <= 16'h0000;
      pbytes_r       <= '0;
    end else begin
      if (cfg_we) begin
        image_blocks_r <= cfg_wdata;
      end
      cs_r     <= cs_nxt;
      err_r    <= err_nxt;
      wc_r     <= wc_nxt;
      ba_r     <= ba_nxt;
      da_r     <= da_nxt;
      pend_r   <= pend_nxt;
      pstart_r <= pstart_nxt;
      pbytes_r <= pbytes_nxt;
    end
  end

endmodule

@@ hw/rtl/cartridge_disk_dma_controller_core.sv @@
// Top level of the cartridge disk DMA controller register front end.
//
// in_ch carries one bus beat: a register read, a register write or a DMA
// completion. out_ch returns exactly one result beat per request beat, in
// order: read data, interrupt level and, when a read or write command passes
// its checks, the DMA command (start, direction, bus address, disk offset,
// byte count).
// cfg_we/cfg_wdata load the image size in 512-byte blocks; write it only
// while no request is in flight.
// After acceptance a request passes the input register, then the decode and
// register update, then the result register, which presents it on out_ch;
// a stall at the receiver can hold it there.
// Throughput is one beat per cycle while out_ch is ready; the register
// update is a single pass of decode, one constant multiply, adds, compares.
// Synchronous reset (rst_n low) empties both stages, sets control/status to
// done, clears the other registers and loads an image size of 4872 blocks.
// When the receiver stalls, the result register holds its beat and the input
// register keeps the next one; in_ch.ready drops only when both are full.
module cartridge_disk_dma_controller_core (
  input  logic                   clk,
  input  logic                   rst_n,
  cdd_req_if.sink                in_ch,
  cdd_rsp_if.source              out_ch,
  input  logic                   cfg_we,
  input  cdd_pkg::image_blocks_t cfg_wdata
);
  import cdd_pkg::*;

  logic     in_valid_r;
  cdd_req_t in_req_r;
  logic     out_valid_r;
  cdd_rsp_t out_rsp_r;
  cdd_rsp_t rsp;
  logic     out_free;
  logic     fire;

  assign out_free    = !out_valid_r || out_ch.ready;
  assign fire        = in_valid_r && out_free;
  assign in_ch.ready = !in_valid_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      in_req_r.req_type   <= in_ch.req_type;
      in_req_r.reg_index  <= in_ch.reg_index;
      in_req_r.write_data <= in_ch.write_data;
      in_req_r.dma_ok     <= in_ch.dma_ok;
    end
  end

  cdd_regfile u_regfile (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .fire      (fire),
    .req       (in_req_r),
    .rsp       (rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= fire;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_rsp_r <= rsp;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.read_data       = out_rsp_r.read_data;
  assign out_ch.irq_level       = out_rsp_r.irq_level;
  assign out_ch.dma_start       = out_rsp_r.dma_start;
  assign out_ch.dma_to_memory   = out_rsp_r.dma_to_memory;
  assign out_ch.dma_bus_addr    = out_rsp_r.dma_bus_addr;
  assign out_ch.dma_disk_offset = out_rsp_r.dma_disk_offset;
  assign out_ch.dma_byte_count  = out_rsp_r.dma_byte_count;

endmodule
